@@ rtl/rrvd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrvd_pkg
// Shared constants and types of the radial ripple vertex displacement block.
// ----------------------------------------------------------------------------
package rrvd_pkg;

  localparam int FRAC_BITS = 4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  // 2H offset (20 in Q.F) and ripple radius offset (100 in Q.F).
  localparam logic signed [17:0] H2_OFFSET = 18'sd20 <<< FRAC_BITS;
  localparam logic signed [17:0] R_OFFSET  = 18'sd100 <<< FRAC_BITS;

  // pi/4 in Q16.
  localparam logic [15:0] PI4_Q16 = 16'd51472;

  // Taylor coefficients of the cosine in Q30.
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [30:0] C2_Q30  = 31'd536870912;
  localparam logic [30:0] C4_Q30  = 31'd44739243;
  localparam logic [30:0] C6_Q30  = 31'd1491308;
  localparam logic [30:0] C8_Q30  = 31'd26631;

  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS  = 16;

  // Control and passthrough data that travels with every item.
  typedef struct packed {
    logic        vld;
    logic        inb;
    logic [15:0] z;
  } side_t;

endpackage
`default_nettype wire

@@ rtl/rrvd_sqrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrvd_sqrt_cell
// One restoring square root step: brings in two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
module rrvd_sqrt_cell (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   en,
  input  rrvd_pkg::side_t       side_in,
  input  wire  [47:0]           rad_in,
  input  wire  [25:0]           rem_in,
  input  wire  [23:0]           root_in,
  output rrvd_pkg::side_t       side_out,
  output logic [47:0]           rad_out,
  output logic [25:0]           rem_out,
  output logic [23:0]           root_out
);

  logic [27:0] rem2;
  logic [27:0] trial;
  logic        take;

  always_comb begin
    rem2  = {rem_in, rad_in[47:46]};
    trial = {2'b00, root_in, 2'b01};
    take  = (rem2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.vld <= 1'b0;
    end else if (en) begin
      side_out.vld <= side_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out.inb <= side_in.inb;
      side_out.z   <= side_in.z;
      rad_out      <= {rad_in[45:0], 2'b00};
      rem_out      <= take ? 26'(rem2 - trial) : rem2[25:0];
      root_out     <= {root_in[22:0], take};
    end
  end

endmodule
`default_nettype wire

@@ rtl/rrvd_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrvd_div_cell
// One restoring division step of the band angle, one quotient bit per cell.
// ----------------------------------------------------------------------------
module rrvd_div_cell (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   en,
  input  wire  [22:0]           divisor,
  input  rrvd_pkg::side_t       side_in,
  input  wire  [22:0]           rem_in,
  input  wire  [15:0]           quo_in,
  output rrvd_pkg::side_t       side_out,
  output logic [22:0]           rem_out,
  output logic [15:0]           quo_out
);

  logic [23:0] rem2;
  logic        take;

  always_comb begin
    rem2 = {rem_in, 1'b0};
    take = (rem2 >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.vld <= 1'b0;
    end else if (en) begin
      side_out.vld <= side_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out.inb <= side_in.inb;
      side_out.z   <= side_in.z;
      rem_out      <= take ? 23'(rem2 - {1'b0, divisor}) : rem2[22:0];
      quo_out      <= {quo_in[14:0], take};
    end
  end

endmodule
`default_nettype wire

@@ rtl/rrvd_cos_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrvd_cos_cell
// One Horner step of the cosine series: s_out = COEF - floor(u * s_in / 2^30).
// ----------------------------------------------------------------------------
module rrvd_cos_cell #(
  parameter logic [30:0] COEF = rrvd_pkg::ONE_Q30
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   en,
  input  rrvd_pkg::side_t       side_in,
  input  wire  [29:0]           u_in,
  input  wire  [30:0]           s_in,
  output rrvd_pkg::side_t       side_out,
  output logic [29:0]           u_out,
  output logic [30:0]           s_out
);

  logic [60:0] prod;

  always_comb begin
    prod = {31'd0, u_in} * {30'd0, s_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.vld <= 1'b0;
    end else if (en) begin
      side_out.vld <= side_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out.inb <= side_in.inb;
      side_out.z   <= side_in.z;
      u_out        <= u_in;
      s_out        <= COEF - prod[60:30];
    end
  end

endmodule
`default_nettype wire

@@ rtl/radial_ripple_vertex_displace.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radial_ripple_vertex_displace
// Displaces the z of a mesh vertex by a cosine ripple around a ring.
// ----------------------------------------------------------------------------
// Usage notes.
// A vertex item (vertex_x, vertex_y, vertex_z) enters on the vertex channel and
// one result item (displaced_z, in_band) leaves on the result channel, in order.
// All values are signed Q12.4. The block is a fully pipelined row of cells:
// one input stage forms x*x + y*y, 24 square root cells give the radius, one
// stage compares it with the ring, 16 divider cells give the angle, one stage
// squares it, four cells evaluate the cosine series, one stage scales it by
// five times the wave height and the output register adds and saturates.
// The throughput is one item per cycle while the receiver takes every result.
// The whole row advances together: when the result register holds an item that
// the receiver does not take, every stage holds and vertex_ready drops in the
// same cycle; it rises again as soon as the result is taken.
// The configuration port (cfg_index, cfg_data) is always ready; index 0 is the
// radius setting, index 1 the height setting, other indexes are ignored. Write
// it only while no item is in flight. Reset clears both settings and empties
// the pipeline; no clearing pass is needed.
// ----------------------------------------------------------------------------
module radial_ripple_vertex_displace (
  input  wire                clk,
  input  wire                rst,
  input  wire                vertex_valid,
  output logic               vertex_ready,
  input  wire  signed [15:0] vertex_x,
  input  wire  signed [15:0] vertex_y,
  input  wire  signed [15:0] vertex_z,
  output logic               result_valid,
  input  wire                result_ready,
  output logic signed [15:0] displaced_z,
  output logic               in_band,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [1:0]         cfg_index,
  input  wire  [15:0]        cfg_data
);

  localparam int NS = rrvd_pkg::SQRT_STEPS;
  localparam int ND = rrvd_pkg::DIV_STEPS;

  // Settings and values derived from them.
  logic signed [15:0] radius_setting;
  logic signed [15:0] height_setting;
  logic signed [17:0] h2;
  logic [15:0]        h2u;
  logic [31:0]        wq_prod;
  logic               band_ok;
  logic [22:0]        wq;
  logic [17:0]        h2x5;
  logic signed [26:0] rbig;

  logic en;

  assign cfg_ready    = 1'b1;
  assign en           = !result_valid || result_ready;
  assign vertex_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_setting <= '0;
      height_setting <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rrvd_pkg::REG_RADIUS) begin
        radius_setting <= cfg_data;
      end
      if (cfg_index == rrvd_pkg::REG_HEIGHT) begin
        height_setting <= cfg_data;
      end
    end
  end

  // Derived values are registered; the pipeline needs them many cycles later.
  always_comb begin
    h2      = 18'(height_setting) + rrvd_pkg::H2_OFFSET;
    h2u     = h2[15:0];
    wq_prod = h2u * rrvd_pkg::PI4_Q16;
  end

  always_ff @(posedge clk) begin
    band_ok <= (h2 > 18'sd0);
    wq      <= wq_prod[30:8];
    h2x5    <= {2'b00, h2u} + {h2u, 2'b00};
    rbig    <= (27'(radius_setting) <<< 9) + (27'(rrvd_pkg::R_OFFSET) <<< 8);
  end

  // Input stage: squared radius.
  rrvd_pkg::side_t s0_side;
  logic [47:0]     s0_rad;
  logic [31:0]     sq_x;
  logic [31:0]     sq_y;

  always_comb begin
    sq_x = 32'(vertex_x * vertex_x);
    sq_y = 32'(vertex_y * vertex_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_side.vld <= 1'b0;
    end else if (en) begin
      s0_side.vld <= vertex_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side.inb <= 1'b0;
      s0_side.z   <= vertex_z;
      s0_rad      <= {sq_x + sq_y, 16'd0};
    end
  end

  // Square root row.
  rrvd_pkg::side_t sq_side [NS+1];
  logic [47:0]     sq_rad  [NS+1];
  logic [25:0]     sq_rem  [NS+1];
  logic [23:0]     sq_root [NS+1];

  assign sq_side[0] = s0_side;
  assign sq_rad[0]  = s0_rad;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    rrvd_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .side_in  (sq_side[i]),
      .rad_in   (sq_rad[i]),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .side_out (sq_side[i+1]),
      .rad_out  (sq_rad[i+1]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1])
    );
  end

  // Band test: distance from the ring against the half width.
  rrvd_pkg::side_t bt_side;
  logic [22:0]     bt_rem;
  logic signed [26:0] ring_dist;
  logic [26:0]     adist;
  logic            in_ring;

  always_comb begin
    ring_dist = $signed({3'b000, sq_root[NS]}) - rbig;
    adist     = ring_dist[26] ? 27'(-ring_dist) : 27'(ring_dist);
    in_ring   = band_ok && (adist < {4'd0, wq});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bt_side.vld <= 1'b0;
    end else if (en) begin
      bt_side.vld <= sq_side[NS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bt_side.inb <= in_ring;
      bt_side.z   <= sq_side[NS].z;
      bt_rem      <= in_ring ? adist[22:0] : '0;
    end
  end

  // Division row: angle magnitude in Q16.
  rrvd_pkg::side_t dv_side [ND+1];
  logic [22:0]     dv_rem  [ND+1];
  logic [15:0]     dv_quo  [ND+1];

  assign dv_side[0] = bt_side;
  assign dv_rem[0]  = bt_rem;
  assign dv_quo[0]  = '0;

  for (genvar i = 0; i < ND; i++) begin : g_div
    rrvd_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .divisor  (wq),
      .side_in  (dv_side[i]),
      .rem_in   (dv_rem[i]),
      .quo_in   (dv_quo[i]),
      .side_out (dv_side[i+1]),
      .rem_out  (dv_rem[i+1]),
      .quo_out  (dv_quo[i+1])
    );
  end

  // Square of the angle in Q30.
  rrvd_pkg::side_t ang_side;
  logic [29:0]     ang_u;
  logic [31:0]     ang_sq;

  assign ang_sq = dv_quo[ND] * dv_quo[ND];

  always_ff @(posedge clk) begin
    if (rst) begin
      ang_side.vld <= 1'b0;
    end else if (en) begin
      ang_side.vld <= dv_side[ND].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_side.inb <= dv_side[ND].inb;
      ang_side.z   <= dv_side[ND].z;
      ang_u        <= ang_sq[31:2];
    end
  end

  // Cosine row, one Horner step per cell.
  localparam logic [30:0] COS_COEF [4] = '{rrvd_pkg::C6_Q30, rrvd_pkg::C4_Q30,
                                           rrvd_pkg::C2_Q30, rrvd_pkg::ONE_Q30};

  rrvd_pkg::side_t cs_side [5];
  logic [29:0]     cs_u    [5];
  logic [30:0]     cs_s    [5];

  assign cs_side[0] = ang_side;
  assign cs_u[0]    = ang_u;
  assign cs_s[0]    = rrvd_pkg::C8_Q30;

  for (genvar i = 0; i < 4; i++) begin : g_cos
    rrvd_cos_cell #(
      .COEF (COS_COEF[i])
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .side_in  (cs_side[i]),
      .u_in     (cs_u[i]),
      .s_in     (cs_s[i]),
      .side_out (cs_side[i+1]),
      .u_out    (cs_u[i+1]),
      .s_out    (cs_s[i+1])
    );
  end

  // Scale by 5 * 2H.
  rrvd_pkg::side_t sc_side;
  logic [48:0]     sc_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_side.vld <= 1'b0;
    end else if (en) begin
      sc_side.vld <= cs_side[4].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_side.inb <= cs_side[4].inb;
      sc_side.z   <= cs_side[4].z;
      sc_prod     <= {31'd0, h2x5} * {18'd0, cs_s[4]};
    end
  end

  // Round, add to z and saturate into the result register; out-of-band items keep z.
  logic [48:0]        sc_round;
  logic signed [19:0] sum;
  logic signed [15:0] res_sat;

  always_comb begin
    sc_round = sc_prod + (49'd1 <<< 30);
    sum      = 20'(signed'(sc_side.z)) + $signed({2'b00, sc_round[48:31]});
    if (sum > 20'sd32767) begin
      res_sat = 16'sh7fff;
    end else if (sum < -20'sd32768) begin
      res_sat = 16'sh8000;
    end else begin
      res_sat = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= sc_side.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_band     <= sc_side.inb;
      displaced_z <= sc_side.inb ? res_sat : sc_side.z;
    end
  end

endmodule
`default_nettype wire

@@ rtl/rrvd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrvd_checker
// Port-level checks of the radial ripple vertex displacement block.
// ----------------------------------------------------------------------------
module rrvd_checker (
  input wire        clk,
  input wire        rst,
  input wire        vertex_ready,
  input wire        result_valid,
  input wire        result_ready,
  input wire [15:0] displaced_z,
  input wire        in_band
);

  // The pipeline holds exactly when a result waits untaken.
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    vertex_ready == (!result_valid || result_ready))
    else $error("vertex_ready does not follow the result register");

  // No result appears right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(displaced_z) && $stable(in_band))
    else $error("result changed while stalled");

endmodule

bind radial_ripple_vertex_displace rrvd_checker u_rrvd_checker (
  .clk          (clk),
  .rst          (rst),
  .vertex_ready (vertex_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .displaced_z  (displaced_z),
  .in_band      (in_band)
);
`default_nettype wire

@@ tb/radial_ripple_vertex_displace_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_ripple_vertex_displace_checker
// Watches the vertex, result and configuration channels of the ripple block,
// predicts each displaced z with an integer model of the ring and compares.
// ----------------------------------------------------------------------------
module radial_ripple_vertex_displace_checker (
  input  wire               clk,
  input  wire               rst,
  input  wire               vertex_valid,
  input  wire               vertex_ready,
  input  wire signed [15:0] vertex_x,
  input  wire signed [15:0] vertex_y,
  input  wire signed [15:0] vertex_z,
  input  wire               result_valid,
  input  wire               result_ready,
  input  wire signed [15:0] displaced_z,
  input  wire               in_band,
  input  wire               cfg_valid,
  input  wire               cfg_ready,
  input  wire        [1:0]  cfg_index,
  input  wire        [15:0] cfg_data,
  output int                fail_count,
  output int                pending_count
);

  typedef struct packed {
    logic signed [15:0] z;
    logic               band;
  } ripple_t;

  ripple_t ripple_q[$];
  logic signed [15:0] radius_reg;
  logic signed [15:0] height_reg;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned ripple_cos(longint a);
    longint unsigned m;
    longint unsigned u;
    longint unsigned s;
    m = (a < 0) ? -a : a;
    u = (m * m) >> 2;
    s = rrvd_pkg::C8_Q30;
    s = rrvd_pkg::C6_Q30 - ((u * s) >> 30);
    s = rrvd_pkg::C4_Q30 - ((u * s) >> 30);
    s = rrvd_pkg::C2_Q30 - ((u * s) >> 30);
    return rrvd_pkg::ONE_Q30 - ((u * s) >> 30);
  endfunction

  function automatic ripple_t displace(longint x, longint y, longint z);
    ripple_t o;
    longint h2, rbig, wq, rq, d, ad, a, disp, res;
    longint unsigned c, v;
    h2 = longint'(height_reg) + (20 <<< rrvd_pkg::FRAC_BITS);
    res = z;
    o.band = 1'b0;
    if (h2 > 0) begin
      rbig = (2 * longint'(radius_reg) + (100 <<< rrvd_pkg::FRAC_BITS)) * 256;
      wq = (h2 * rrvd_pkg::PI4_Q16) / 256;
      rq = int_sqrt(longint'(x * x + y * y) * 65536);
      d = rq - rbig;
      ad = (d < 0) ? -d : d;
      if (ad < wq) begin
        a = (d * 65536) / wq;
        c = ripple_cos(a);
        v = longint'(5 * h2) * c;
        disp = (v + (64'd1 << 30)) >> 31;
        res = z + disp;
        o.band = 1'b1;
      end
    end
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    o.z = res[15:0];
    return o;
  endfunction

  assign pending_count = ripple_q.size();

  always @(posedge clk) begin
    ripple_t e;
    int nerr;
    nerr = 0;
    if (rst) begin
      radius_reg <= '0;
      height_reg <= '0;
      fail_count <= 0;
      ripple_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rrvd_pkg::REG_RADIUS) radius_reg <= cfg_data;
        else if (cfg_index == rrvd_pkg::REG_HEIGHT) height_reg <= cfg_data;
      end
      if (vertex_valid && vertex_ready)
        ripple_q.push_back(displace(vertex_x, vertex_y, vertex_z));
      if (result_valid && result_ready) begin
        if (ripple_q.size() == 0) begin
          $error("unexpected result item displaced_z=%0d", displaced_z);
          nerr = nerr + 1;
        end else begin
          e = ripple_q.pop_front();
          if (e.z !== displaced_z) begin
            $error("displaced_z expected %0d actual %0d", e.z, displaced_z);
            nerr = nerr + 1;
          end
          if (e.band !== in_band) begin
            $error("in_band expected %0d actual %0d", e.band, in_band);
            nerr = nerr + 1;
          end
        end
      end
      fail_count <= fail_count + nerr;
    end
  end
endmodule

@@ tb/radial_ripple_vertex_displace_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_ripple_vertex_displace_tb
// Drives vertex items and register writes into the ripple block under several
// ring settings and idling patterns; the checker judges every result item.
// ----------------------------------------------------------------------------
module radial_ripple_vertex_displace_tb;

  localparam int LATENCY = 49;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic vertex_valid;
  logic vertex_ready;
  logic signed [15:0] vertex_x, vertex_y, vertex_z;
  logic result_valid;
  logic result_ready;
  logic signed [15:0] displaced_z;
  logic in_band;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  int fail_count;
  int pending_count;
  int send_idle_pct;
  int recv_idle_pct;
  longint cycle_count;

  radial_ripple_vertex_displace dut (.*);
  radial_ripple_vertex_displace_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random; the share changes from phase to phase.
  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Runaway guard: the slowest legal run is far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one vertex and hold it until the block takes it. Idle cycles come
  // first so valid never drops while an item is pending; valid stays high
  // after acceptance and is dropped by the next idle cycle or by a drain.
  task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      vertex_valid <= 1'b0;
      @(posedge clk);
    end
    vertex_valid <= 1'b1;
    vertex_x <= x;
    vertex_y <= y;
    vertex_z <= z;
    do @(posedge clk); while (!vertex_ready);
  endtask

  // The first edge lets the checker record the item accepted last.
  task automatic drain_results();
    vertex_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Registers change only with the pipeline empty.
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A point on or near the ripple ring for the current radius, so random items
  // land both inside and just outside the band when the band exists.
  task automatic send_near_ring(int radius_val, int height_val);
    int ring, spread, r, ang, xv, yv;
    real th;
    ring = 2 * radius_val + 1600;
    spread = (height_val + 320 > 0) ? (height_val + 320) * 2 : 64;
    r = ring + $signed($urandom_range(2 * spread)) - spread;
    if (r < 0) r = -r;
    if (r > 46000) r = 46000;
    ang = $urandom_range(359);
    th = ang * 3.14159265 / 180.0;
    xv = $rtoi(r * $cos(th));
    yv = $rtoi(r * $sin(th));
    if (xv > 32767) xv = 32767;
    if (xv < -32768) xv = -32768;
    if (yv > 32767) yv = 32767;
    if (yv < -32768) yv = -32768;
    send_vertex(xv[15:0], yv[15:0], 16'($urandom()));
  endtask

  int radius_set[6] = '{0, -32768, 32767, 200, -800, 5000};
  int height_set[6] = '{0, 32767, -32768, -320, -319, 1000};

  initial begin
    int k;
    rst = 1'b1;
    vertex_valid = 1'b0;
    vertex_x = '0;
    vertex_y = '0;
    vertex_z = '0;
    cfg_valid = 1'b0;
    cfg_index = rrvd_pkg::REG_RADIUS;
    cfg_data = '0;
    result_ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cycle_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items with reset settings: origin, extremes, ring centre, points
    // outside the band on both sides, z at both ends with saturation at the top.
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_vertex(16'h8000, 16'h8000, 16'h8000);
    send_vertex(16'h8000, 16'h0000, 16'h7FFF);
    send_vertex(16'sd1600, 16'sd0, 16'h7FFF);
    send_vertex(16'sd1600, 16'sd0, 16'h8000);
    send_vertex(16'sd0, -16'sd1600, 16'sd100);
    send_vertex(16'sd1098, 16'sd0, 16'sd0);
    send_vertex(16'sd2102, 16'sd0, 16'sd0);
    send_vertex(16'sd1100, 16'sd0, 16'sd0);
    send_vertex(16'sd2100, 16'sd0, 16'sd0);
    send_vertex(16'sd1131, 16'sd1131, -16'sd5);
    send_vertex(16'h5555, 16'hAAAA, 16'h5A5A);
    // An unknown register index must be ignored.
    write_reg(2'd2, 16'hFFFF);
    write_reg(2'd3, 16'h1234);
    send_vertex(16'sd1600, 16'sd0, 16'sd0);
    // Wave height at zero, below zero (empty band) and just above zero.
    write_reg(rrvd_pkg::REG_HEIGHT, 16'hFEC0);
    send_vertex(16'sd1600, 16'sd0, 16'sd7);
    write_reg(rrvd_pkg::REG_HEIGHT, 16'h8000);
    send_vertex(16'sd1600, 16'sd0, 16'sd7);
    write_reg(rrvd_pkg::REG_HEIGHT, 16'hFEC1);
    send_vertex(16'sd1600, 16'sd0, 16'sd7);
    write_reg(rrvd_pkg::REG_RADIUS, 16'h0000);
    write_reg(rrvd_pkg::REG_HEIGHT, 16'h0000);

    // Random part in three idling phases, each walking through the settings.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 52 : 0;
      recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 33 : 0;
      for (int s = 0; s < 6; s++) begin
        write_reg(rrvd_pkg::REG_RADIUS, radius_set[(s + phase) % 6][15:0]);
        write_reg(rrvd_pkg::REG_HEIGHT, height_set[s][15:0]);
        for (k = 0; k < 67; k++) begin
          if ($urandom_range(3) == 0)
            send_vertex(16'($urandom()), 16'($urandom()), 16'($urandom()));
          else
            send_near_ring(radius_set[(s + phase) % 6], height_set[s]);
          // Sender holds off until the pipeline runs dry.
          if (k == 30) drain_results();
        end
      end
    end

    drain_results();
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
